[sv/vnorm_pkg.sv]
// ----------------------------------------------------------------------------
// vnorm_pkg
// Shared sizes and side-band type for the 3D vector normaliser.
// ----------------------------------------------------------------------------
package vnorm_pkg;

  localparam int COMP_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int LANES      = 3;
  localparam int SUM_W      = 2 * COMP_WIDTH;
  localparam int ROOT_W     = COMP_WIDTH;
  localparam int QUO_W      = FRAC_BITS + 1;
  localparam int NUM_W      = COMP_WIDTH + FRAC_BITS;

  typedef struct packed {
    logic [LANES-1:0][COMP_WIDTH-1:0] mag;
    logic [LANES-1:0]                 neg;
    logic                             zero;
  } side_t;

endpackage

[sv/vnorm_req_if.sv]
// ----------------------------------------------------------------------------
// vnorm_req_if
// Request channel: one vector per transfer.
// ----------------------------------------------------------------------------
interface vnorm_req_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [vnorm_pkg::COMP_WIDTH-1:0]    in_x;
  logic signed [vnorm_pkg::COMP_WIDTH-1:0]    in_y;
  logic signed [vnorm_pkg::COMP_WIDTH-1:0]    in_z;

  modport source (output valid, in_x, in_y, in_z, input ready);
  modport sink   (input valid, in_x, in_y, in_z, output ready);
endinterface

[sv/vnorm_rsp_if.sv]
// ----------------------------------------------------------------------------
// vnorm_rsp_if
// Response channel: one unit vector and zero flag per transfer.
// ----------------------------------------------------------------------------
interface vnorm_rsp_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [vnorm_pkg::COMP_WIDTH-1:0]    unit_x;
  logic signed [vnorm_pkg::COMP_WIDTH-1:0]    unit_y;
  logic signed [vnorm_pkg::COMP_WIDTH-1:0]    unit_z;
  logic                                       zero_length;

  modport source (output valid, unit_x, unit_y, unit_z, zero_length, input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, zero_length, output ready);
endinterface

[sv/vnorm_sq.sv]
// ----------------------------------------------------------------------------
// vnorm_sq
// Per-component lane: magnitude, sign and square, registered.
// ----------------------------------------------------------------------------
module vnorm_sq (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic signed [vnorm_pkg::COMP_WIDTH-1:0] comp,
  output logic [vnorm_pkg::COMP_WIDTH-1:0]        mag,
  output logic                                    neg,
  output logic [vnorm_pkg::SUM_W-1:0]             sq
);
  logic [vnorm_pkg::COMP_WIDTH-1:0] mag_next;

  assign mag_next = comp[vnorm_pkg::COMP_WIDTH-1] ? (~comp + 1'b1) : comp;

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= mag_next;
      neg <= comp[vnorm_pkg::COMP_WIDTH-1];
      sq  <= vnorm_pkg::SUM_W'(mag_next) * vnorm_pkg::SUM_W'(mag_next);
    end
  end
endmodule

[sv/vnorm_sqrt.sv]
// ----------------------------------------------------------------------------
// vnorm_sqrt
// Pipelined integer square root, one root bit per stage, side-band carried.
// ----------------------------------------------------------------------------
module vnorm_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [vnorm_pkg::SUM_W-1:0]   sum,
  input  vnorm_pkg::side_t              side_in,
  output logic [vnorm_pkg::ROOT_W-1:0]  root,
  output vnorm_pkg::side_t              side_out
);
  localparam int Stages = vnorm_pkg::ROOT_W;
  localparam int TW     = vnorm_pkg::SUM_W + 2;

  logic [vnorm_pkg::SUM_W-1:0]  rem_r  [Stages];
  logic [vnorm_pkg::ROOT_W-1:0] root_r [Stages];
  vnorm_pkg::side_t             side_r [Stages];

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    localparam int B = Stages - 1 - k;
    logic [vnorm_pkg::SUM_W-1:0]  rem_i;
    logic [vnorm_pkg::ROOT_W-1:0] root_i;
    vnorm_pkg::side_t             side_i;
    logic [TW-1:0]                trial;
    logic [TW-1:0]                diff;

    if (k == 0) begin : g_first
      assign rem_i  = sum;
      assign root_i = '0;
      assign side_i = side_in;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign trial = (TW'(root_i) << (B + 1)) | (TW'(1) << (2 * B));
    assign diff  = TW'(rem_i) - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_i;
        if (TW'(rem_i) >= trial) begin
          rem_r[k]  <= diff[vnorm_pkg::SUM_W-1:0];
          root_r[k] <= root_i | (vnorm_pkg::ROOT_W'(1) << B);
        end else begin
          rem_r[k]  <= rem_i;
          root_r[k] <= root_i;
        end
      end
    end
  end

  assign root     = root_r[Stages-1];
  assign side_out = side_r[Stages-1];
endmodule

[sv/vnorm_div.sv]
// ----------------------------------------------------------------------------
// vnorm_div
// Pipelined restoring divider, one quotient bit per stage: (mag << F) / len.
// ----------------------------------------------------------------------------
module vnorm_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic [vnorm_pkg::COMP_WIDTH-1:0]  mag,
  input  logic [vnorm_pkg::ROOT_W-1:0]      len,
  output logic [vnorm_pkg::QUO_W-1:0]       quo
);
  localparam int Stages = vnorm_pkg::QUO_W;
  localparam int DW     = vnorm_pkg::ROOT_W + vnorm_pkg::FRAC_BITS + 1;

  logic [DW-1:0]                rem_r [Stages];
  logic [vnorm_pkg::QUO_W-1:0]  quo_r [Stages];
  logic [vnorm_pkg::ROOT_W-1:0] len_r [Stages];

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    localparam int B = Stages - 1 - k;
    logic [DW-1:0]                rem_i;
    logic [vnorm_pkg::QUO_W-1:0]  quo_i;
    logic [vnorm_pkg::ROOT_W-1:0] len_i;
    logic [DW-1:0]                trial;

    if (k == 0) begin : g_first
      assign rem_i = DW'(mag) << vnorm_pkg::FRAC_BITS;
      assign quo_i = '0;
      assign len_i = len;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign quo_i = quo_r[k-1];
      assign len_i = len_r[k-1];
    end

    assign trial = DW'(len_i) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        len_r[k] <= len_i;
        if (rem_i >= trial) begin
          rem_r[k] <= rem_i - trial;
          quo_r[k] <= quo_i | (vnorm_pkg::QUO_W'(1) << B);
        end else begin
          rem_r[k] <= rem_i;
          quo_r[k] <= quo_i;
        end
      end
    end
  end

  assign quo = quo_r[Stages-1];
endmodule

[sv/vector3_normalize_core.sv]
// ----------------------------------------------------------------------------
// vector3_normalize_core
// Normalises a signed fixed-point 3D vector to unit length.
//
//   channel  dir  fields                                   handshake
//   req      in   in_x, in_y, in_z                          valid/ready
//   rsp      out  unit_x, unit_y, unit_z, zero_length       valid/ready
//
// One vector per cycle while rsp is not stalled; ROOT_W + QUO_W + 3 register
// stages: lane squares, sum, the bit-per-stage square root, the three lane
// dividers and the output register.
// Synchronous reset clears the stage valid bits only.
// A stalled response freezes the whole pipeline; req.ready follows it.
// ----------------------------------------------------------------------------
module vector3_normalize_core (
  input  logic        clk,
  input  logic        rst,
  vnorm_req_if.sink   req,
  vnorm_rsp_if.source rsp
);
  localparam int Depth = vnorm_pkg::ROOT_W + vnorm_pkg::QUO_W + 3;
  localparam int CW    = vnorm_pkg::COMP_WIDTH;
  localparam int EW    = (vnorm_pkg::QUO_W > CW ? vnorm_pkg::QUO_W : CW) + 1;

  logic [Depth-1:0] vld;
  logic             adv;

  logic signed [CW-1:0]        comp   [vnorm_pkg::LANES];
  logic [CW-1:0]               mag    [vnorm_pkg::LANES];
  logic                        neg    [vnorm_pkg::LANES];
  logic [vnorm_pkg::SUM_W-1:0] sq     [vnorm_pkg::LANES];
  logic [vnorm_pkg::SUM_W-1:0] sum;
  vnorm_pkg::side_t            side_s;
  logic [vnorm_pkg::ROOT_W-1:0] root;
  vnorm_pkg::side_t            side_r;
  vnorm_pkg::side_t            side_d [vnorm_pkg::QUO_W];
  logic [vnorm_pkg::QUO_W-1:0] quo    [vnorm_pkg::LANES];
  logic [CW-1:0]               res    [vnorm_pkg::LANES];

  function automatic logic [CW-1:0] apply_sign(input logic [vnorm_pkg::QUO_W-1:0] q,
                                               input logic n);
    logic [EW-1:0] qe;
    logic [EW-1:0] lim;
    qe  = EW'(q);
    lim = EW'(1) << (CW - 1);
    if (n) begin
      if (qe > lim) qe = lim;
      return CW'(~qe + 1'b1);
    end
    if (qe > lim - 1'b1) qe = lim - 1'b1;
    return CW'(qe);
  endfunction

  assign adv       = !vld[Depth-1] || rsp.ready;
  assign req.ready = adv;
  assign rsp.valid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], req.valid};
    end
  end

  assign comp[0] = req.in_x;
  assign comp[1] = req.in_y;
  assign comp[2] = req.in_z;

  for (genvar i = 0; i < vnorm_pkg::LANES; i++) begin : g_lane
    vnorm_sq u_sq (
      .clk  (clk),
      .en   (adv),
      .comp (comp[i]),
      .mag  (mag[i]),
      .neg  (neg[i]),
      .sq   (sq[i])
    );

    vnorm_div u_div (
      .clk (clk),
      .en  (adv),
      .mag (side_r.mag[i]),
      .len (root),
      .quo (quo[i])
    );

    assign res[i] = side_d[vnorm_pkg::QUO_W-1].zero ? '0 :
                    apply_sign(quo[i], side_d[vnorm_pkg::QUO_W-1].neg[i]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum <= sq[0] + sq[1] + sq[2];
      for (int i = 0; i < vnorm_pkg::LANES; i++) begin
        side_s.mag[i] <= mag[i];
        side_s.neg[i] <= neg[i];
      end
      side_s.zero <= (sq[0] | sq[1] | sq[2]) == '0;
    end
  end

  vnorm_sqrt u_sqrt (
    .clk      (clk),
    .en       (adv),
    .sum      (sum),
    .side_in  (side_s),
    .root     (root),
    .side_out (side_r)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      side_d[0] <= side_r;
      for (int k = 1; k < vnorm_pkg::QUO_W; k++) begin
        side_d[k] <= side_d[k-1];
      end
      rsp.unit_x      <= res[0];
      rsp.unit_y      <= res[1];
      rsp.unit_z      <= res[2];
      rsp.zero_length <= side_d[vnorm_pkg::QUO_W-1].zero;
    end
  end
endmodule
